// File: hw/rtl/gpre_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package gpre_pkg;

    localparam int FRAME_BYTES  = 6;
    localparam int STORE_BYTES  = FRAME_BYTES - 1;
    localparam int POS_W        = 3;
    localparam int NUM_BUTTONS  = 14;
    localparam int PAD_BUTTONS  = 10;
    localparam int IDX_W        = 4;
    localparam int DZ_W         = 15;
    localparam int AXIS_W       = 16;
    localparam int TIME_W       = 32;
    localparam int IN_W         = 40;
    localparam int OUT_W        = 72;

    localparam logic [DZ_W-1:0]  DZ_RESET    = 15'd4096;
    localparam logic [7:0]       BTN_HI_MASK = 8'h03;

    localparam int DIR_UP       = 0;
    localparam int DIR_DOWN     = 1;
    localparam int DIR_LEFT     = 2;
    localparam int DIR_RIGHT    = 3;
    localparam int FIRST_BUTTON = 4;

    typedef enum logic {
        ST_IDLE,
        ST_SCAN
    } t_state;

    typedef struct packed {
        logic take;
        logic emit;
    } t_cmd;

    typedef struct packed {
        logic frame_end;
        logic out_free;
        logic last_emit;
    } t_stat;

    function automatic logic [IDX_W-1:0] lowest_set(input logic [NUM_BUTTONS-1:0] v);
        logic [IDX_W-1:0] idx;
        idx = '0;
        for (int i = NUM_BUTTONS - 1; i >= 0; i--) begin
            if (v[i]) begin
                idx = IDX_W'(i);
            end
        end
        return idx;
    endfunction

endpackage

`default_nettype wire

// File: hw/rtl/gpre_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none

module gpre_ctrl (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           s_axis_tvalid,
    output logic                s_axis_tready,
    input  wire gpre_pkg::t_stat i_stat,
    output gpre_pkg::t_cmd      o_cmd
);
    import gpre_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state       = r_state;
        s_axis_tready = 1'b0;
        o_cmd         = '0;
        case (r_state)
            ST_IDLE: begin
                s_axis_tready = 1'b1;
                o_cmd.take    = s_axis_tvalid;
                if (s_axis_tvalid && i_stat.frame_end) begin
                    n_state = ST_SCAN;
                end
            end
            ST_SCAN: begin
                o_cmd.emit = i_stat.out_free;
                if (i_stat.out_free && i_stat.last_emit) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    a_no_take_in_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_SCAN) |-> !o_cmd.take)
        else $error("byte taken during scan");

    a_emit_needs_slot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.emit |-> i_stat.out_free)
        else $error("emit without free output slot");

    a_frame_end_scans: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_cmd.take && i_stat.frame_end) |=> (r_state == ST_SCAN))
        else $error("completed frame not scanned");

endmodule

`default_nettype wire

// File: hw/rtl/gpre_dp.sv
`timescale 1ns / 1ps
`default_nettype none

module gpre_dp (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire gpre_pkg::t_cmd                i_cmd,
    output gpre_pkg::t_stat                    o_stat,
    input  wire logic [gpre_pkg::IN_W-1:0]     i_in_data,
    input  wire logic                          i_cfg_valid,
    input  wire logic [gpre_pkg::DZ_W-1:0]     i_cfg_data,
    input  wire logic                          i_out_ready,
    output logic                               o_out_valid,
    output logic [gpre_pkg::OUT_W-1:0]         o_out_data,
    output logic                               o_out_user,
    output logic                               o_out_last
);
    import gpre_pkg::*;

    logic [DZ_W-1:0]        r_dead_zone;
    logic [POS_W-1:0]       r_pos;
    logic [7:0]             r_bytes [STORE_BYTES];
    logic [NUM_BUTTONS-1:0] r_prev;
    logic [NUM_BUTTONS-1:0] r_pend;
    logic [NUM_BUTTONS-1:0] r_cur;
    logic [TIME_W-1:0]      r_time;
    logic [AXIS_W-1:0]      r_ax;
    logic [AXIS_W-1:0]      r_ay;
    logic                   r_out_valid;
    logic [OUT_W-1:0]       r_out_data;
    logic                   r_out_user;
    logic                   r_out_last;

    logic [7:0]             in_byte;
    logic [TIME_W-1:0]      in_time;
    logic [AXIS_W-1:0]      ax;
    logic [AXIS_W-1:0]      ay;
    logic signed [AXIS_W:0] x_ext;
    logic signed [AXIS_W:0] y_ext;
    logic signed [AXIS_W:0] dz_pos;
    logic signed [AXIS_W:0] dz_neg;
    logic [NUM_BUTTONS-1:0] cur;
    logic [IDX_W-1:0]       scan_idx;
    logic [NUM_BUTTONS-1:0] n_pend;
    logic                   frame_end;

    assign in_byte   = i_in_data[7:0];
    assign in_time   = i_in_data[IN_W-1:8];
    assign frame_end = (r_pos >= POS_W'(STORE_BYTES));

    assign ax     = {r_bytes[3], r_bytes[2]};
    assign ay     = {in_byte, r_bytes[4]};
    assign x_ext  = {ax[AXIS_W-1], ax};
    assign y_ext  = {ay[AXIS_W-1], ay};
    assign dz_pos = {2'b00, r_dead_zone};
    assign dz_neg = -dz_pos;

    always_comb begin
        cur                         = '0;
        cur[DIR_RIGHT]              = (x_ext > dz_pos);
        cur[DIR_LEFT]               = (x_ext < dz_neg);
        cur[DIR_DOWN]               = (y_ext > dz_pos);
        cur[DIR_UP]                 = (y_ext < dz_neg);
        cur[FIRST_BUTTON +: PAD_BUTTONS] =
            PAD_BUTTONS'({r_bytes[1] & BTN_HI_MASK, r_bytes[0]});
    end

    assign scan_idx = lowest_set(r_pend);
    assign n_pend   = r_pend & (r_pend - NUM_BUTTONS'(1));

    assign o_stat.frame_end = frame_end;
    assign o_stat.out_free  = !r_out_valid || i_out_ready;
    assign o_stat.last_emit = (n_pend == '0);

    // config register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dead_zone <= DZ_RESET;
        end else if (i_cfg_valid) begin
            r_dead_zone <= i_cfg_data;
        end
    end

    // byte collection and frame latch
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos  <= '0;
            r_prev <= '0;
        end else if (i_cmd.take) begin
            if (frame_end) begin
                r_pos  <= '0;
                r_prev <= cur;
            end else begin
                r_pos  <= r_pos + POS_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.take && !frame_end) begin
            r_bytes[r_pos] <= in_byte;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.take && frame_end) begin
            r_pend <= cur ^ r_prev;
            r_cur  <= cur;
            r_time <= in_time;
            r_ax   <= ax;
            r_ay   <= ay;
        end else if (i_cmd.emit) begin
            r_pend <= n_pend;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.emit) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            if (r_pend == '0) begin
                r_out_data <= {3'b000, r_ay, r_ax, r_time, 1'b0, {IDX_W{1'b0}}};
                r_out_user <= 1'b0;
            end else begin
                r_out_data <= {3'b000, r_ay, r_ax, r_time, r_cur[scan_idx], scan_idx};
                r_out_user <= 1'b1;
            end
            r_out_last <= (n_pend == '0);
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;
    assign o_out_user  = r_out_user;
    assign o_out_last  = r_out_last;

    a_pos_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pos <= POS_W'(STORE_BYTES))
        else $error("byte position out of range");

    a_take_emit_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_cmd.take && i_cmd.emit))
        else $error("take and emit together");

    a_pend_shrinks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.emit && r_pend != '0) |=>
            ($countones(r_pend) + 1 == $countones($past(r_pend))))
        else $error("scan did not retire exactly one change");

endmodule

`default_nettype wire

// File: hw/rtl/gamepad_report_edge_events.sv
// first result of a frame: registered from the scan state that follows its sixth byte
// throughput: one byte beat per cycle within a frame; after the sixth byte the scan
//   writes max(1, changed buttons) results, up to 14, into the output register, one per
//   cycle while the output is not stalled
// the first byte of the next frame is not taken until the scan has issued the final result
// reset (synchronous, active low): position 0, previous map all released, dead zone 4096,
//   output register empty; the frame byte store is left as is
`timescale 1ns / 1ps
`default_nettype none

module gamepad_report_edge_events (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          s_axis_tvalid,
    output logic                               s_axis_tready,
    // byte_value, time_ms
    input  wire logic [gpre_pkg::IN_W-1:0]     s_axis_tdata,
    output logic                               m_axis_tvalid,
    input  wire logic                          m_axis_tready,
    // button_index, pressed, event_time_ms, axis_x, axis_y, zero pad
    output logic [gpre_pkg::OUT_W-1:0]         m_axis_tdata,
    // has_event
    output logic [0:0]                         m_axis_tuser,
    output logic                               m_axis_tlast,
    input  wire logic                          i_cfg_valid,
    output logic                               o_cfg_ready,
    input  wire logic [gpre_pkg::DZ_W-1:0]     i_cfg_data
);
    import gpre_pkg::*;

    t_cmd  cmd;
    t_stat stat;
    logic  out_user;

    assign o_cfg_ready  = 1'b1;
    assign m_axis_tuser = out_user;

    gpre_ctrl u_ctrl (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .i_stat        (stat),
        .o_cmd         (cmd)
    );

    gpre_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_stat      (stat),
        .i_in_data   (s_axis_tdata),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_data  (i_cfg_data),
        .i_out_ready (m_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .o_out_data  (m_axis_tdata),
        .o_out_user  (out_user),
        .o_out_last  (m_axis_tlast)
    );

endmodule

`default_nettype wire
